FILE: hw/rtl/pds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg
// Shared constants, types and the divider step for the divider search core.
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam logic [7:0] M_MIN = 8'd2;
    localparam logic [7:0] M_MAX = 8'd128;
    localparam logic [7:0] D_MIN = 8'd1;
    localparam logic [7:0] D_MAX = 8'd106;
    localparam logic [7:0] O_MIN = 8'd1;
    localparam logic [7:0] O_MAX = 8'd128;

    localparam logic [19:0] HZ_PER_MHZ = 20'd1000000;

    localparam logic [29:0] REF_RST  = 30'd100000000;
    localparam logic [29:0] ERR_RST  = 30'd50000;
    localparam logic [11:0] VMIN_RST = 12'd800;
    localparam logic [11:0] VMAX_RST = 12'd1600;
    localparam logic [31:0] RATE_RST = 32'd300000000;

    localparam int PROD_W = 38;
    localparam int DV_STG = 10;
    localparam int DV_BPS = 4;
    localparam int DV_W   = DV_STG * DV_BPS;

    typedef enum logic [2:0] {
        CFG_REF  = 3'd0,
        CFG_ERR  = 3'd1,
        CFG_VMIN = 3'd2,
        CFG_VMAX = 3'd3,
        CFG_RATE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic            vld;
        logic [DV_W-1:0] num;
        logic [7:0]      rem;
        logic [7:0]      den;
        logic [7:0]      tag;
    } t_dv;

    // DV_BPS restoring steps; quotient bits shift in at the bottom of num
    function automatic t_dv dv_step(input t_dv a);
        t_dv        r;
        logic [8:0] t;
        r = a;
        for (int i = 0; i < DV_BPS; i++) begin
            t     = {r.rem, r.num[DV_W-1]};
            r.num = {r.num[DV_W-2:0], 1'b0};
            if (t >= {1'b0, r.den}) begin
                r.rem    = 8'(t - {1'b0, r.den});
                r.num[0] = 1'b1;
            end else begin
                r.rem = t[7:0];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pll_divider_search_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pll_divider_search_core
// Searches M, D, O for the first triple whose output is within the error bound.
// ----------------------------------------------------------------------------
// Steps: per M value the product ref*M is registered; per (M,D) pair the VCO is divided by D,
//   and for pairs whose VCO is in the window O is swept until a hit, which flushes the divider.
// Requests: one at a time; the 11-stage divider pipeline is shared by both divisions.
// Result strobe o_valid lasts one cycle; the receiver cannot stall.
// Reset: synchronous, active low; config registers take their defaults.
module pll_divider_search_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [31:0] i_target_hz,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    output logic             o_found,
    output logic [7:0]       o_mult,
    output logic [7:0]       o_in_div,
    output logic [7:0]       o_out_div,
    output logic [31:0]      o_achieved_hz
);
    import pds_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PROD  = 7'b0000010,
        S_VISS  = 7'b0000100,
        S_VWAIT = 7'b0001000,
        S_OISS  = 7'b0010000,
        S_ODRN  = 7'b0100000,
        S_FLUSH = 7'b1000000
    } t_state;

    logic [29:0] r_ref, r_err;
    logic [11:0] r_vmin, r_vmax;
    logic [31:0] r_rate;

    t_state            r_st, n_st;
    logic [31:0]       r_tgt, r_lo, r_hi;
    logic [7:0]        r_m, n_m, r_d, n_d, r_o, n_o;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_vco, n_vco;
    t_dv               r_dv [0:DV_STG];
    logic              r_valid, n_valid, r_found, n_found;
    logic [7:0]        r_rm, n_rm, r_rd, n_rd, r_ro, n_ro;
    logic [31:0]       r_ach, n_ach;

    t_dv               iss;
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] diff;
    logic              hit, in_win, any_vld;
    t_cfg_idx          cidx;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_st != S_IDLE) || r_valid;
    assign o_valid     = r_valid;
    assign o_found     = r_found;
    assign o_mult      = r_rm;
    assign o_in_div    = r_rd;
    assign o_out_div   = r_ro;
    assign o_achieved_hz = r_ach;
    assign cidx        = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= REF_RST;
            r_err  <= ERR_RST;
            r_vmin <= VMIN_RST;
            r_vmax <= VMAX_RST;
            r_rate <= RATE_RST;
        end else if (i_cfg_valid) begin
            unique case (cidx)
                CFG_REF:  r_ref  <= i_cfg_data[29:0];
                CFG_ERR:  r_err  <= i_cfg_data[29:0];
                CFG_VMIN: r_vmin <= i_cfg_data[11:0];
                CFG_VMAX: r_vmax <= i_cfg_data[11:0];
                CFG_RATE: r_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divider pipeline
    assign q = r_dv[DV_STG].num[PROD_W-1:0];
    always_comb begin
        any_vld = 1'b0;
        for (int k = 0; k <= DV_STG; k++) any_vld = any_vld | r_dv[k].vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DV_STG; k++) r_dv[k].vld <= 1'b0;
        end else begin
            r_dv[0] <= iss;
            for (int k = 0; k < DV_STG; k++) r_dv[k+1] <= dv_step(r_dv[k]);
        end
    end

    assign in_win = ({6'd0, r_lo} <= q) && (q <= {6'd0, r_hi});
    assign diff   = (q > {6'd0, r_tgt}) ? q - {6'd0, r_tgt} : {6'd0, r_tgt} - q;
    assign hit    = r_dv[DV_STG].vld && (diff < {8'd0, r_err});

    always_comb begin
        n_st    = r_st;
        n_m     = r_m;
        n_d     = r_d;
        n_o     = r_o;
        n_vco   = r_vco;
        n_valid = 1'b0;
        n_found = r_found;
        n_rm    = r_rm;
        n_rd    = r_rd;
        n_ro    = r_ro;
        n_ach   = r_ach;
        iss     = '0;
        unique case (r_st) inside
            S_IDLE: begin
                if (i_start && !o_busy) begin
                    n_m     = M_MIN;
                    n_d     = D_MIN;
                    n_found = 1'b0;
                    n_rm    = '0;
                    n_rd    = '0;
                    n_ro    = '0;
                    n_ach   = '0;
                    if ((M_MIN > M_MAX) || (D_MIN > D_MAX) || (O_MIN > O_MAX))
                        n_valid = 1'b1;
                    else
                        n_st = S_PROD;
                end
            end
            S_PROD: n_st = S_VISS;
            S_VISS: begin
                iss.vld = 1'b1;
                iss.num = DV_W'(r_prod);
                iss.den = r_d;
                n_st    = S_VWAIT;
            end
            S_VWAIT: begin
                if (r_dv[DV_STG].vld) begin
                    if (in_win) begin
                        n_vco = q;
                        n_o   = O_MIN;
                        n_st  = S_OISS;
                    end else if (r_d != D_MAX) begin
                        n_d  = r_d + 8'd1;
                        n_st = S_VISS;
                    end else if (r_m != M_MAX) begin
                        n_m  = r_m + 8'd1;
                        n_d  = D_MIN;
                        n_st = S_PROD;
                    end else begin
                        n_valid = 1'b1;
                        n_st    = S_IDLE;
                    end
                end
            end
            S_OISS, S_ODRN: begin
                if (r_st == S_OISS) begin
                    iss.vld = 1'b1;
                    iss.num = DV_W'(r_vco);
                    iss.den = r_o;
                    iss.tag = r_o;
                    if (r_o == O_MAX) n_st = S_ODRN;
                    else n_o = r_o + 8'd1;
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_rm    = r_m;
                    n_rd    = r_d;
                    n_ro    = r_dv[DV_STG].tag;
                    n_ach   = q[31:0];
                    n_st    = S_FLUSH;
                end else if (r_dv[DV_STG].vld && r_dv[DV_STG].tag == O_MAX) begin
                    if (r_d != D_MAX) begin
                        n_d  = r_d + 8'd1;
                        n_st = S_VISS;
                    end else if (r_m != M_MAX) begin
                        n_m  = r_m + 8'd1;
                        n_d  = D_MIN;
                        n_st = S_PROD;
                    end else begin
                        n_valid = 1'b1;
                        n_st    = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (!any_vld) begin
                    n_valid = 1'b1;
                    n_st    = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_valid <= n_valid;
        end
        r_m     <= n_m;
        r_d     <= n_d;
        r_o     <= n_o;
        r_vco   <= n_vco;
        r_found <= n_found;
        r_rm    <= n_rm;
        r_rd    <= n_rd;
        r_ro    <= n_ro;
        r_ach   <= n_ach;
        r_prod  <= PROD_W'(r_ref) * PROD_W'(r_m);
        if (r_st == S_IDLE) begin
            r_tgt <= (i_target_hz > r_rate) ? r_rate : i_target_hz;
            r_lo  <= {20'd0, r_vmin} * {12'd0, HZ_PER_MHZ};
            r_hi  <= {20'd0, r_vmax} * {12'd0, HZ_PER_MHZ};
        end
    end

endmodule
`default_nettype wire
